// File: rtl/sppt_pkg.sv
// ----------------------------------------------------------------------------
// sppt_pkg: shared types and constants of the subset pattern penalty table
// Holds the penalty width, the register codes and the walk states.
// ----------------------------------------------------------------------------
package sppt_pkg;

	localparam int PEN_W = 15;

	typedef enum logic [0:0] {
		REG_LOOKUP_ENABLE = 1'b0,
		REG_DEADLOCK      = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_SHIFT,
		ST_DONE
	} state_t;

endpackage

// File: rtl/sppt_cell.sv
// ----------------------------------------------------------------------------
// sppt_cell: one table entry of the chain
// Holds pattern, forbidden set and penalty; while rot is set it takes the entry
// of its neighbor toward the tail (one step toward cell 0), or load_new takes the insert data.
// ----------------------------------------------------------------------------
module sppt_cell #(
	parameter int SQ = 256
) (
	input  logic                      clk,
	input  logic                      rot,      // advance ring one step
	input  logic                      load_new, // take new entry instead
	input  logic [SQ-1:0]             prev_pat,
	input  logic [SQ-1:0]             prev_fb,
	input  logic [sppt_pkg::PEN_W-1:0] prev_pen,
	input  logic [SQ-1:0]             new_pat,
	input  logic [SQ-1:0]             new_fb,
	input  logic [sppt_pkg::PEN_W-1:0] new_pen,
	output logic [SQ-1:0]             pat,
	output logic [SQ-1:0]             fb,
	output logic [sppt_pkg::PEN_W-1:0] pen
);
	import sppt_pkg::*;

	logic [SQ-1:0]    pat_q, fb_q;
	logic [PEN_W-1:0] pen_q;

	always_ff @(posedge clk) begin
		if (load_new) begin
			pat_q <= new_pat;
			fb_q  <= new_fb;
			pen_q <= new_pen;
		end else if (rot) begin
			pat_q <= prev_pat;
			fb_q  <= prev_fb;
			pen_q <= prev_pen;
		end
	end

	assign pat = pat_q;
	assign fb  = fb_q;
	assign pen = pen_q;
endmodule

// File: rtl/subset_pattern_penalty_table_top.sv
// ----------------------------------------------------------------------------
// subset_pattern_penalty_table_top: greedy subset pattern penalty table
// Sorted entry table kept in a ring of cells, walked one entry per cycle.
// ----------------------------------------------------------------------------
// Use: pulse start with func and the square sets while busy is low. For a
// query the table is walked and penalty_sum appears with done for one cycle.
// For an insert the same walk gives the prior penalty; if stored, the ring
// then rotates once more to place the new entry in sorted position.
// Entries sit in a ring of TABLE_ENTRIES cells; each cycle the ring rotates one
// step and cell 0 is checked, so a walk visits every cell no matter
// how many entries are live (dead slots are skipped by the fill count).
// The DONE state after the walk settles the total and decides the insert.
// One item at a time; busy drops in the cycle done is high. Results cannot be
// stalled.
// Reset clears the fill count and the registers (lookup enabled, deadlock
// 32767); entry contents are not cleared and are never read before written.
// Config through APB, lookup_enable at 0x0, deadlock_value at 0x4.
// ----------------------------------------------------------------------------
module subset_pattern_penalty_table_top #(
	parameter int TABLE_ENTRIES = 64,
	parameter int BOARD_SQUARES = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        start,
	output logic        busy,
	input  logic        func,
	input  logic [63:0] squares_w0,
	input  logic [63:0] squares_w1,
	input  logic [63:0] squares_w2,
	input  logic [63:0] squares_w3,
	input  logic [63:0] forbid_w0,
	input  logic [63:0] forbid_w1,
	input  logic [63:0] forbid_w2,
	input  logic [63:0] forbid_w3,
	input  logic [14:0] new_penalty,
	input  logic [7:0]  man_square,
	output logic        done,
	output logic [14:0] penalty_sum,
	output logic        stored,
	output logic        table_full
);
	import sppt_pkg::*;

	localparam int SQ  = BOARD_SQUARES;
	localparam int N   = TABLE_ENTRIES;
	localparam int IW  = $clog2(N);
	localparam int CW  = $clog2(N + 1);

	// config
	logic             en_q;
	logic [PEN_W-1:0] dl_q;
	logic             wr;
	reg_idx_t         ridx;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign ridx   = reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q <= 1'b1;
			dl_q <= '1;
		end else if (wr && paddr[1:0] == 2'b00) begin
			unique case (ridx)
				REG_LOOKUP_ENABLE: en_q <= pwdata[0];
				REG_DEADLOCK:      dl_q <= pwdata[PEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[1:0] == 2'b00) begin
			unique case (ridx)
				REG_LOOKUP_ENABLE: prdata[0] = en_q;
				REG_DEADLOCK:      prdata[PEN_W-1:0] = dl_q;
				default: ;
			endcase
		end
	end

	// item latch
	logic [255:0]     sq_all, fb_all;
	logic [SQ-1:0]    left_q, npat_q, nfb_q, man_oh_q;
	logic             func_q;
	logic [PEN_W-1:0] npen_q, pen_new;

	assign sq_all = {squares_w3, squares_w2, squares_w1, squares_w0};
	assign fb_all = {forbid_w3, forbid_w2, forbid_w1, forbid_w0};

	// ring of cells
	logic [SQ-1:0]    c_pat [N];
	logic [SQ-1:0]    c_fb  [N];
	logic [PEN_W-1:0] c_pen [N];
	logic [N-1:0]     ld;
	logic             rot;

	// write-back into the tail cell: redirect it to the new or carried entry
	logic [SQ-1:0]    w_pat, w_fb;
	logic [PEN_W-1:0] w_pen;
	logic             w_sel;

	for (genvar i = 0; i < N; i++) begin : g_cell
		localparam int P = (i + 1) % N;
		sppt_cell #(.SQ(SQ)) u_cell (
			.clk(clk), .rot(rot), .load_new(ld[i]),
			.prev_pat(c_pat[P]), .prev_fb(c_fb[P]), .prev_pen(c_pen[P]),
			.new_pat(w_pat), .new_fb(w_fb), .new_pen(w_pen),
			.pat(c_pat[i]), .fb(c_fb[i]), .pen(c_pen[i])
		);
	end

	// walk control
	state_t           st_q, st_d;
	logic [IW-1:0]    step_q;
	logic             step_last;
	logic [CW-1:0]    cnt_q;
	logic [15:0]      tot_q;
	logic             dead_q, placed_q;
	logic [PEN_W-1:0] res_q;
	logic             live, nonempty, subset, forb, hit;
	logic [15:0]      tsum;
	logic [PEN_W-1:0] prior;
	logic             want, room, go_ins;

	// cell 0 holds entry step_q during the walk: the ring rotates toward 0
	assign step_last = (step_q == IW'(N - 1));
	assign live      = CW'(step_q) < cnt_q;
	assign nonempty  = |c_pat[0];
	assign subset    = ~|(c_pat[0] & ~left_q);
	assign forb      = |(c_fb[0] & man_oh_q);
	assign hit       = live && !dead_q && nonempty && subset && !forb;
	assign tsum      = tot_q + 16'(c_pen[0]);

	always_comb begin
		prior = tot_q[PEN_W-1:0];
		if (!en_q) prior = '0;
		else if (!dead_q && tot_q[0] && tot_q[PEN_W-1:0] != dl_q) prior = tot_q[PEN_W-1:0] + 1'b1;
	end

	assign want   = func_q && (prior < npen_q);
	assign room   = cnt_q < CW'(N);
	assign go_ins = want && room;

	always_comb begin
		logic [15:0] s;
		s = 16'(npen_q) + 16'(prior);
		pen_new = (s > 16'(dl_q)) ? dl_q : s[PEN_W-1:0];
	end

	// insert pass: the ring rotates once more; the tail takes the new entry at
	// the first lower-penalty or dead slot, then each following entry one late
	logic [SQ-1:0]    k_pat_q, k_fb_q;
	logic [PEN_W-1:0] k_pen_q;
	logic             ins_pt;

	assign ins_pt = (st_q == ST_SHIFT) && !placed_q && (!live || c_pen[0] < pen_new);
	assign w_sel  = ins_pt || (st_q == ST_SHIFT && placed_q);
	assign w_pat  = ins_pt ? npat_q  : k_pat_q;
	assign w_fb   = ins_pt ? nfb_q   : k_fb_q;
	assign w_pen  = ins_pt ? pen_new : k_pen_q;
	assign rot    = (st_q == ST_WALK) || (st_q == ST_SHIFT);

	always_comb begin
		ld = '0;
		ld[N-1] = w_sel;
	end

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE:  if (start) st_d = ST_WALK;
			ST_WALK:  if (step_last) st_d = ST_DONE;
			ST_DONE:  st_d = go_ins ? ST_SHIFT : ST_IDLE;
			ST_SHIFT: if (step_last) st_d = ST_IDLE;
			default:  st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			step_q <= '0;
			cnt_q <= '0;
			done <= 1'b0;
			stored <= 1'b0;
			table_full <= 1'b0;
			placed_q <= 1'b0;
			res_q <= '0;
		end else begin
			st_q <= st_d;
			done <= 1'b0;
			if (rot) step_q <= step_last ? '0 : step_q + 1'b1;
			else step_q <= '0;
			if (st_q == ST_DONE) begin
				stored <= go_ins;
				table_full <= want && !room;
				res_q <= prior;
				placed_q <= 1'b0;
				done <= !go_ins;
			end
			if (ins_pt) placed_q <= 1'b1;
			if (st_q == ST_SHIFT && step_last) begin
				cnt_q <= cnt_q + 1'b1;
				done <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && start) begin
			left_q   <= sq_all[SQ-1:0];
			npat_q   <= sq_all[SQ-1:0];
			nfb_q    <= fb_all[SQ-1:0];
			man_oh_q <= SQ'(1) << man_square;
			func_q   <= func;
			npen_q   <= new_penalty;
			tot_q    <= '0;
			dead_q   <= 1'b0;
		end else if (st_q == ST_WALK && hit) begin
			if (tsum >= 16'(dl_q)) begin
				tot_q  <= 16'(dl_q);
				dead_q <= 1'b1;
			end else begin
				tot_q  <= tsum;
				left_q <= left_q & ~c_pat[0];
			end
		end
	end

	// carry register: holds the entry displaced by the insert
	always_ff @(posedge clk) begin
		if (w_sel) begin
			k_pat_q <= c_pat[0];
			k_fb_q  <= c_fb[0];
			k_pen_q <= c_pen[0];
		end
	end

	assign busy        = (st_q != ST_IDLE);
	assign penalty_sum = res_q;
endmodule

// File: rtl/sppt_checker.sv
// ----------------------------------------------------------------------------
// sppt_checker: port-level checks of the subset pattern penalty table
// Watches the command handshake and result flags.
// ----------------------------------------------------------------------------
module sppt_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic stored,
	input logic table_full
);
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("done without busy");
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(stored && table_full)) else $error("stored and full");
	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("item not taken");
endmodule

bind subset_pattern_penalty_table_top sppt_checker u_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
	.done(done), .stored(stored), .table_full(table_full)
);

// File: tb/sv/subset_pattern_penalty_table_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// subset_pattern_penalty_table_top_test: self-checking bench for the table
// Drives queries and inserts with random gaps, predicts every result with a
// behavioral copy of the sorted table, and walks the APB registers through
// several settings between phases.
// ----------------------------------------------------------------------------
module subset_pattern_penalty_table_top_test;
	import sppt_pkg::*;

	localparam int ENTRIES = 64;
	localparam int SETTLE  = 2 * ENTRIES + 8;
	localparam int WD_LIMIT = 4000;

	typedef struct {
		logic        func;
		logic [255:0] squares;
		logic [255:0] forbid;
		logic [14:0] new_pen;
		logic [7:0]  man;
	} cmd_t;

	typedef struct {
		logic [14:0] sum;
		logic        stored;
		logic        full;
	} res_t;

	class penalty_scoreboard;
		logic [255:0] pat[ENTRIES];
		logic [255:0] fbd[ENTRIES];
		logic [14:0]  pen[ENTRIES];
		int           fill;
		logic         enable;
		logic [14:0]  deadlock;
		res_t         pending[$];
		int           errors;

		function new();
			fill = 0;
			enable = 1'b1;
			deadlock = 15'h7fff;
			errors = 0;
		endfunction

		function logic [14:0] walk(logic [255:0] stones, logic [7:0] man);
			logic [255:0] left;
			int total;
			bit dead;
			left = stones;
			total = 0;
			dead = 0;
			if (!enable) return 15'd0;
			for (int e = 0; e < fill; e++) begin
				if (pat[e] != 0 && (pat[e] & ~left) == 0 && !fbd[e][man]) begin
					total += pen[e];
					if (total >= deadlock) begin
						total = deadlock;
						dead = 1;
						break;
					end
					left &= ~pat[e];
				end
			end
			if (!dead && total[0] && total != deadlock) total++;
			return total[14:0];
		endfunction

		function void note_cmd(cmd_t c);
			res_t r;
			int p, pos;
			r.sum = walk(c.squares, c.man);
			r.stored = 0;
			r.full = 0;
			if (c.func && r.sum < c.new_pen) begin
				if (fill >= ENTRIES) begin
					r.full = 1;
				end else begin
					p = c.new_pen + r.sum;
					if (p > deadlock) p = deadlock;
					pos = 0;
					while (pos < fill && pen[pos] >= p) pos++;
					for (int k = fill; k > pos; k--) begin
						pat[k] = pat[k-1];
						fbd[k] = fbd[k-1];
						pen[k] = pen[k-1];
					end
					pat[pos] = c.squares;
					fbd[pos] = c.forbid;
					pen[pos] = p[14:0];
					fill++;
					r.stored = 1;
				end
			end
			pending.push_back(r);
		endfunction

		function void check_res(res_t a);
			res_t x;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result sum=%0d stored=%0b full=%0b",
					$time, a.sum, a.stored, a.full);
				errors++;
				return;
			end
			x = pending.pop_front();
			if (a.sum !== x.sum) begin
				$display("%0t: penalty_sum expected %0d actual %0d", $time, x.sum, a.sum);
				errors++;
			end
			if (a.stored !== x.stored) begin
				$display("%0t: stored expected %0b actual %0b", $time, x.stored, a.stored);
				errors++;
			end
			if (a.full !== x.full) begin
				$display("%0t: table_full expected %0b actual %0b", $time, x.full, a.full);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0, arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [2:0] paddr = 0;
	logic [31:0] pwdata = 0, prdata;
	logic pready, start = 0, busy, func = 0, done, stored, table_full;
	logic [63:0] squares_w0 = 0, squares_w1 = 0, squares_w2 = 0, squares_w3 = 0;
	logic [63:0] forbid_w0 = 0, forbid_w1 = 0, forbid_w2 = 0, forbid_w3 = 0;
	logic [14:0] new_penalty = 0, penalty_sum;
	logic [7:0] man_square = 0;

	penalty_scoreboard sb = new();
	int idle_cycles = 0;

	subset_pattern_penalty_table_top dut (.*);

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	always @(posedge clk) begin
		if (done) sb.check_res('{penalty_sum, stored, table_full});
		if (done || (start && !busy) || (psel && penable)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WD_LIMIT) begin
			$display("[subset_pattern_penalty_table_top] ERROR");
			$finish;
		end
	end

	task automatic write_reg(reg_idx_t idx, logic [14:0] val);
		@(negedge clk);
		psel = 1; penable = 0; pwrite = 1;
		paddr = {idx, 2'b00};
		pwdata = {17'd0, val};
		@(negedge clk);
		penable = 1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (idx == REG_LOOKUP_ENABLE) sb.enable = val[0];
		else sb.deadlock = val;
		@(negedge clk);
		psel = 0; penable = 0; pwrite = 0;
	endtask

	task automatic drain();
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic send_cmd(cmd_t c);
		repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16)) @(negedge clk);
		@(negedge clk);
		while (busy) @(negedge clk);
		start = 1;
		func = c.func;
		{squares_w3, squares_w2, squares_w1, squares_w0} = c.squares;
		{forbid_w3, forbid_w2, forbid_w1, forbid_w0} = c.forbid;
		new_penalty = c.new_pen;
		man_square = c.man;
		@(posedge clk);
		sb.note_cmd(c);
		@(negedge clk);
		start = 0;
	endtask

	function automatic logic [255:0] rand_wide();
		return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom};
	endfunction

	// sparse sets so patterns actually fit inside stone sets
	function automatic logic [255:0] sparse_set(int n);
		logic [255:0] s = 0;
		for (int i = 0; i < n; i++) s[$urandom_range(0, 255)] = 1;
		return s;
	endfunction

	function automatic cmd_t rand_cmd(logic [14:0] pen_max);
		cmd_t c;
		c.func = ($urandom_range(0, 2) == 0);
		c.squares = sparse_set($urandom_range(0, 6));
		if ($urandom_range(0, 9) == 0) c.squares = rand_wide();
		c.forbid = $urandom_range(0, 1) ? sparse_set($urandom_range(0, 40)) : 256'd0;
		if ($urandom_range(0, 9) == 0) c.forbid = rand_wide();
		c.new_pen = 15'($urandom_range(0, pen_max));
		if ($urandom_range(0, 15) == 0) c.new_pen = 15'($urandom_range(0, 32767));
		c.man = 8'($urandom_range(0, 255));
		if (!c.func && $urandom_range(0, 1)) c.squares |= rand_wide() | sparse_set(30);
		return c;
	endfunction

	initial begin
		cmd_t c;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: empty table, empty pattern, extremes, forbidden man, odd, deadlock
		send_cmd('{1'b0, '1, '1, 15'h7fff, 8'hff});
		send_cmd('{1'b1, 256'd0, 256'd0, 15'd100, 8'd0});
		send_cmd('{1'b1, 256'h3, 256'd1 << 5, 15'd7, 8'd0});
		send_cmd('{1'b0, 256'h7, 256'd0, 15'd0, 8'd5});
		send_cmd('{1'b0, 256'h7, 256'd0, 15'd0, 8'd6});
		send_cmd('{1'b1, 256'h3, 256'd0, 15'd3, 8'd1});
		send_cmd('{1'b1, 256'h3, 256'd0, 15'd20, 8'd1});
		send_cmd('{1'b1, 256'h1 << 255, '1, 15'h7fff, 8'd0});
		send_cmd('{1'b1, 256'h1 << 255, 256'd0, 15'h7fff, 8'd255});
		send_cmd('{1'b0, '1, 256'd0, 15'd0, 8'd255});
		send_cmd('{1'b0, 256'h1 << 255 | 256'h3, 256'd0, 15'd0, 8'd0});
		drain();
		write_reg(REG_DEADLOCK, 15'd2);
		send_cmd('{1'b0, 256'h3, 256'd0, 15'd0, 8'd9});
		send_cmd('{1'b1, 256'h30, 256'd0, 15'd5, 8'd9});
		drain();
		write_reg(REG_LOOKUP_ENABLE, 15'd0);
		send_cmd('{1'b0, '1, 256'd0, 15'd0, 8'd9});
		send_cmd('{1'b1, 256'h300, 256'd0, 15'd1, 8'd9});
		drain();
		write_reg(REG_LOOKUP_ENABLE, 15'd1);
		write_reg(REG_DEADLOCK, 15'h7fff);

		// random phases, each with its own deadlock and enable
		for (int ph = 0; ph < 8; ph++) begin
			logic [14:0] dl;
			case (ph % 4)
				0: dl = 15'h7fff;
				1: dl = 15'd2;
				2: dl = 15'($urandom_range(20, 200));
				default: dl = 15'($urandom_range(2, 32767));
			endcase
			drain();
			write_reg(REG_DEADLOCK, dl);
			write_reg(REG_LOOKUP_ENABLE, (ph == 5) ? 15'd0 : 15'd1);
			for (int i = 0; i < 100; i++) begin
				c = rand_cmd((ph % 4 == 2) ? 15'd120 : 15'd3000);
				send_cmd(c);
			end
		end

		drain();
		if (sb.errors == 0) $display("[subset_pattern_penalty_table_top] OK");
		else $display("[subset_pattern_penalty_table_top] ERROR");
		$finish;
	end
endmodule

// File: sim.f
rtl/sppt_pkg.sv
rtl/sppt_cell.sv
rtl/subset_pattern_penalty_table_top.sv
rtl/sppt_checker.sv
tb/sv/subset_pattern_penalty_table_top_test.sv
